// File: sv/aprf_pkg.sv
// Shared widths, types and register indexes for the all-pole recursive filter.
`timescale 1ns / 1ps
package aprf_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int COEF_W    = 16;
  localparam int COEF_FRAC = 14;
  localparam int NUM_COEF  = 6;
  localparam int ORDER_W   = 3;
  localparam int REG_IDX_W = 3;
  // Truncated product width, then sum of the sample and six products.
  localparam int TERM_W    = SAMPLE_W + COEF_W - COEF_FRAC;
  localparam int ACC_W     = TERM_W + 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef coef_t [NUM_COEF-1:0]       coef_arr_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ORDER  = 3'd0,
    REG_COEF_1 = 3'd1,
    REG_COEF_2 = 3'd2,
    REG_COEF_3 = 3'd3,
    REG_COEF_4 = 3'd4,
    REG_COEF_5 = 3'd5,
    REG_COEF_6 = 3'd6
  } reg_idx_e;

  typedef struct packed {
    sample_t y;
    logic    sat;
  } mac_res_t;

endpackage

// File: sv/aprf_mac.sv
// Feedback multiply-accumulate with floor scaling and 24-bit saturation.
`timescale 1ns / 1ps
module aprf_mac import aprf_pkg::*; #(
  parameter int MAX_ORDER = 6
) (
  input  sample_t              x_i,
  input  logic                 first_i,
  input  logic [ORDER_W-1:0]   order_i,
  input  coef_arr_t            coef_i,
  input  sample_t              hist_i [MAX_ORDER],
  output mac_res_t             res_o
);

  logic signed [SAMPLE_W+COEF_W-1:0] prod [MAX_ORDER];
  logic signed [TERM_W-1:0]          term [MAX_ORDER];
  logic signed [ACC_W-1:0]           acc;

  always_comb begin
    for (int k = 0; k < MAX_ORDER; k++) begin
      prod[k] = hist_i[k] * coef_i[k];
      // arithmetic shift right = floor division by 2^COEF_FRAC
      term[k] = prod[k][SAMPLE_W+COEF_W-1:COEF_FRAC];
    end
  end

  always_comb begin
    acc = ACC_W'(x_i);
    for (int k = 0; k < MAX_ORDER; k++) begin
      // first word sees a cleared history
      if (!first_i && (order_i > ORDER_W'(k))) begin
        acc = acc + ACC_W'(term[k]);
      end
    end
  end

  always_comb begin
    if (acc[ACC_W-1:SAMPLE_W-1] == '0 || acc[ACC_W-1:SAMPLE_W-1] == '1) begin
      res_o.y   = acc[SAMPLE_W-1:0];
      res_o.sat = 1'b0;
    end else begin
      res_o.y   = acc[ACC_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
      res_o.sat = 1'b1;
    end
  end

endmodule

// File: sv/all_pole_recursive_filter.sv
// Top level of the all-pole recursive filter (ARMA psi-weight generator).
`timescale 1ns / 1ps
// y(n) = x(n) + sum_{k=1..order} coef_k * y(n-k), samples Q8.16, coefficients
// Q2.14, products floored, sum saturated to 24 bits (flag in m_axis_tuser_o).
// One word is taken per clock unless the output stalls. The rate is set by the
// feedback loop: six parallel multipliers and the adder tree sit between the
// input register and the history/result registers. tuser on the input side
// clears the history before that word. The user must write registers through
// the cfg port only while idle; the block does not enforce this. filter_order
// above MAX_ORDER acts as MAX_ORDER, unknown indexes are ignored.
module all_pole_recursive_filter import aprf_pkg::*; #(
  parameter int MAX_ORDER = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [23:0]          s_axis_tdata_i,   // [23:0] drive_sample
  input  logic                 s_axis_tuser_i,   // [0] first_item
  input  logic                 s_axis_tlast_i,   // last_item
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [23:0]          m_axis_tdata_o,   // [23:0] response_sample
  output logic                 m_axis_tuser_o,   // [0] saturated
  output logic                 m_axis_tlast_o,   // last_result
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [REG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

  logic [ORDER_W-1:0] order_q;
  coef_arr_t          coef_q;
  logic [ORDER_W-1:0] order_eff;

  logic    in_valid_q, in_valid_d;
  sample_t x_q;
  logic    first_q, last_q;

  logic    out_valid_q, out_valid_d;
  sample_t y_q;
  logic    sat_q, last_out_q;

  sample_t  hist_q [MAX_ORDER];
  mac_res_t res;
  logic     s_accept, advance;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= '0;
      coef_q  <= '0;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_ORDER:  order_q   <= cfg_data_i[ORDER_W-1:0];
        REG_COEF_1: coef_q[0] <= cfg_data_i;
        REG_COEF_2: coef_q[1] <= cfg_data_i;
        REG_COEF_3: coef_q[2] <= cfg_data_i;
        REG_COEF_4: coef_q[3] <= cfg_data_i;
        REG_COEF_5: coef_q[4] <= cfg_data_i;
        REG_COEF_6: coef_q[5] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign order_eff = (order_q > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : order_q;

  // handshake: input register drains into the result register
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      x_q     <= s_axis_tdata_i;
      first_q <= s_axis_tuser_i;
      last_q  <= s_axis_tlast_i;
    end
    if (advance) begin
      y_q        <= res.y;
      sat_q      <= res.sat;
      last_out_q <= last_q;
    end
  end

  aprf_mac #(
    .MAX_ORDER (MAX_ORDER)
  ) u_mac (
    .x_i     (x_q),
    .first_i (first_q),
    .order_i (order_eff),
    .coef_i  (coef_q),
    .hist_i  (hist_q),
    .res_o   (res)
  );

  // newest output first; every word shifts in its result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_ORDER; k++) begin
        hist_q[k] <= '0;
      end
    end else if (advance) begin
      hist_q[0] <= res.y;
      for (int k = 1; k < MAX_ORDER; k++) begin
        hist_q[k] <= first_q ? '0 : hist_q[k-1];
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = y_q;
  assign m_axis_tuser_o  = sat_q;
  assign m_axis_tlast_o  = last_out_q;

endmodule

// File: bench/all_pole_recursive_filter_test.sv
// Self-checking bench for the all-pole recursive filter: stream driver, monitor, predictor.
`timescale 1ns / 1ps
module all_pole_recursive_filter_test;
  import aprf_pkg::*;

  localparam int MAX_ORDER = 6;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam longint SAMPLE_HI = 64'sd8388607;
  localparam longint SAMPLE_LO = -64'sd8388608;
  localparam sample_t SAMPLE_MAXV = 24'sh7FFFFF;
  localparam sample_t SAMPLE_MINV = 24'sh800000;
  localparam sample_t UNIT = 24'sd65536;
  localparam int PRINT_CAP = 60;

  typedef struct packed {
    sample_t x;
    logic    first;
    logic    last;
  } drive_word_t;

  typedef struct packed {
    sample_t y;
    logic    last;
    logic    sat;
  } response_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [23:0]          m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data = '0;

  // predictor state, mirrors the block's registers and history
  logic [ORDER_W-1:0] tap_count = '0;
  coef_t              tap_coef [NUM_COEF] = '{default: '0};
  sample_t            resp_hist [MAX_ORDER] = '{default: '0};

  drive_word_t drive_words [$];
  response_t   pending_responses [$];
  drive_word_t on_bus;
  response_t   resp_want;
  bit          steady = 1'b0;
  int          mismatches = 0;
  int          words_queued = 0;
  int          words_sent = 0;
  int          results_seen = 0;
  int          sat_seen = 0;
  int          sequences = 0;
  reg_idx_e    coef_regs [NUM_COEF] = '{REG_COEF_1, REG_COEF_2, REG_COEF_3,
                                         REG_COEF_4, REG_COEF_5, REG_COEF_6};

  all_pole_recursive_filter #(.MAX_ORDER(MAX_ORDER)) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #6 clk_i = ~clk_i;

  function automatic void apply_reg(logic [REG_IDX_W-1:0] idx, logic [15:0] val);
    if (idx == REG_ORDER) begin
      tap_count = val[ORDER_W-1:0];
    end else if (idx <= REG_COEF_6) begin
      tap_coef[idx - 3'd1] = coef_t'(val);
    end
  endfunction

  // y = x + sum of floored coef*history products, clipped to 24 bits
  function automatic response_t filter_step(drive_word_t w);
    response_t r;
    longint    acc;
    int        taps;
    if (w.first) begin
      foreach (resp_hist[k]) resp_hist[k] = '0;
    end
    taps = (tap_count > MAX_ORDER) ? MAX_ORDER : int'(tap_count);
    acc = longint'(w.x);
    for (int k = 0; k < taps; k++)
      acc += (longint'(resp_hist[k]) * longint'(tap_coef[k])) >>> COEF_FRAC;
    r.sat = 1'b0;
    if (acc > SAMPLE_HI) begin
      acc = SAMPLE_HI;
      r.sat = 1'b1;
    end else if (acc < SAMPLE_LO) begin
      acc = SAMPLE_LO;
      r.sat = 1'b1;
    end
    for (int k = MAX_ORDER - 1; k > 0; k--) resp_hist[k] = resp_hist[k-1];
    resp_hist[0] = sample_t'(acc);
    r.y = sample_t'(acc);
    r.last = w.last;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (mismatches < PRINT_CAP)
      $display("%0t: result %0d %s: got %0d, want %0d", $time, results_seen, what, got, want);
    mismatches++;
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_reg(idx, val);
  endtask

  task automatic queue_word(sample_t x, logic first, logic last);
    drive_words.push_back('{x, first, last});
    words_queued++;
  endtask

  function automatic sample_t small_sample();
    return sample_t'(int'($urandom_range(0, 131072)) - 65536);
  endfunction

  // wait until every queued word came back, then let the pipe settle
  task automatic drain();
    while (results_seen < words_queued)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic random_settings(int p);
    logic [15:0] val;
    val = 16'($urandom());
    val[ORDER_W-1:0] = ORDER_W'(p % 8);
    write_reg(REG_ORDER, val);
    for (int k = 0; k < NUM_COEF; k++) begin
      case (p % 3)
        0: val = 16'($urandom());
        1: val = 16'(int'($urandom_range(0, 8192)) - 4096);
        default: begin
          case ($urandom_range(0, 2))
            0: val = 16'h7FFF;
            1: val = 16'h8000;
            default: val = 16'h0000;
          endcase
        end
      endcase
      write_reg(coef_regs[k], val);
    end
    if (p % 2) write_reg(REG_UNUSED, 16'($urandom()));
  endtask

  // mostly psi-weight style runs (unit impulse, MA terms, zero padding), some noise
  task automatic random_traffic(int n);
    int added;
    int len;
    sample_t x;
    added = 0;
    while (added < n) begin
      if ($urandom_range(0, 3) != 0) begin
        len = $urandom_range(2, 16);
        for (int k = 0; k < len; k++) begin
          if (k == 0) x = ($urandom_range(0, 4) != 0) ? UNIT : small_sample();
          else if (k < len / 2) x = small_sample();
          else x = '0;
          queue_word(x, k == 0, k == len - 1);
        end
        sequences++;
      end else begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++)
          queue_word(sample_t'($urandom()), $urandom_range(0, 7) == 0,
                     1'($urandom_range(0, 1)));
      end
      added += len;
    end
  endtask

  // driver: predict on acceptance, then present the next word or idle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pending_responses.push_back(filter_step(on_bus));
        words_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (drive_words.size() > 0 && (steady || $urandom_range(0, 99) >= 8)) begin
          on_bus = drive_words.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= on_bus.x;
          s_axis_tuser  <= on_bus.first;
          s_axis_tlast  <= on_bus.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_responses.size() == 0) begin
          report_mismatch("without a pending word", longint'(sample_t'(m_axis_tdata)), 0);
        end else begin
          resp_want = pending_responses.pop_front();
          if (m_axis_tdata !== resp_want.y)
            report_mismatch("response_sample", longint'(sample_t'(m_axis_tdata)),
                            longint'(resp_want.y));
          if (m_axis_tlast !== resp_want.last)
            report_mismatch("last_result", m_axis_tlast, resp_want.last);
          if (m_axis_tuser !== resp_want.sat)
            report_mismatch("saturated", m_axis_tuser, resp_want.sat);
        end
        if (m_axis_tuser === 1'b1) sat_seen++;
        results_seen++;
      end
      m_axis_tready <= steady || $urandom_range(0, 99) >= 8;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // registers at reset: order zero, output follows input
    queue_word(SAMPLE_MAXV, 1'b1, 1'b0);
    queue_word(SAMPLE_MINV, 1'b0, 1'b0);
    queue_word('0, 1'b0, 1'b0);
    queue_word(-24'sd1, 1'b0, 1'b0);
    queue_word(24'sd1, 1'b0, 1'b1);
    drain();

    // full order (junk in upper bits of the order write), extreme coefficients
    write_reg(REG_ORDER, 16'hFFFE);
    write_reg(REG_COEF_1, 16'h4000);
    write_reg(REG_COEF_2, 16'h8000);
    write_reg(REG_COEF_3, 16'h7FFF);
    write_reg(REG_COEF_4, 16'h0000);
    write_reg(REG_COEF_5, 16'hFFFF);
    write_reg(REG_COEF_6, 16'h2000);
    write_reg(REG_UNUSED, 16'hFFFF);
    queue_word(UNIT, 1'b1, 1'b0);
    queue_word(24'sd13107, 1'b0, 1'b0);
    queue_word(-24'sd6554, 1'b0, 1'b0);
    queue_word('0, 1'b0, 1'b0);
    queue_word('0, 1'b0, 1'b0);
    queue_word('0, 1'b0, 1'b1);
    // clip high, then clip low after a history clear
    queue_word(SAMPLE_MAXV, 1'b1, 1'b0);
    queue_word(SAMPLE_MAXV, 1'b0, 1'b1);
    queue_word(SAMPLE_MINV, 1'b1, 1'b0);
    queue_word(SAMPLE_MINV, 1'b0, 1'b1);
    drain();

    // order seven acts as six
    write_reg(REG_ORDER, 16'h0007);
    write_reg(REG_COEF_1, 16'h7FFF);
    queue_word(UNIT, 1'b1, 1'b0);
    queue_word('0, 1'b0, 1'b0);
    queue_word('0, 1'b0, 1'b0);
    queue_word(UNIT, 1'b0, 1'b1);
    drain();

    for (int p = 0; p < 14; p++) begin
      steady = (p >= 6 && p <= 8);
      random_settings(p);
      random_traffic(100);
      drain();
    end
    steady = 1'b0;
    repeat (8) @(posedge clk_i);

    $display("Drove %0d words (%0d impulse runs plus noise) over 17 register settings,",
             words_sent, sequences);
    $display("checked %0d results, %0d of them clipped.", results_seen, sat_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_400_000;
    $display("Timed out waiting for the filter");
    $display("Mismatches found");
    $finish;
  end

endmodule
